// ===== sv/reee_pkg.sv =====
// Package for the election engine: widths, codes and helper functions.
`default_nettype none
package reee_pkg;
   localparam int MaxNodesDefault = 256;
   localparam int TimeBitsDefault = 32;
   localparam logic [15:0] SeedReset = 16'd44257;
   localparam logic [15:0] LfsrMask = 16'hB400;
   localparam logic [30:0] TermMax = 31'h7FFF_FFFF;
   localparam logic [2:0] CsrNumRegs = 3'd5;

   typedef enum logic [2:0] {
      ACT_VOTE_REQ = 3'd0, ACT_HEARTBEAT = 3'd1, ACT_GRANT = 3'd2,
      ACT_TIMEOUT = 3'd3, ACT_TICK = 3'd4, ACT_TRIGGER = 3'd5,
      ACT_STEP_DOWN = 3'd6, ACT_NONE = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      KIND_DENIED = 3'd0, KIND_GRANTED = 3'd1, KIND_HB_ACK = 3'd2,
      KIND_VOTE_BCAST = 3'd3, KIND_HB_BCAST = 3'd4, KIND_ELECTED = 3'd5,
      KIND_OK = 3'd6, KIND_RSV = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ROLE_FOL = 2'd0, ROLE_CAND = 2'd1, ROLE_LEAD = 2'd2, ROLE_RSV = 2'd3
   } role_type;

   typedef enum logic [2:0] {
      CSR_OWN_ID = 3'd0, CSR_CLUSTER = 3'd1, CSR_KEEPALIVE = 3'd2,
      CSR_HB_PERIOD = 3'd3, CSR_SEED = 3'd4
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_MOD, ST_FINISH, ST_OUT
   } state_type;

   // Start and status of the serial remainder unit.
   typedef struct packed {
      logic start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic done;
      logic [15:0] remainder;
   } mod_rsp_type;

   function automatic logic [15:0] lfsr_step(input logic [15:0] s);
      logic [15:0] n;
      n = s >> 1;
      if (s[0]) begin
         n = n ^ LfsrMask;
      end
      return n;
   endfunction
endpackage
`default_nettype wire

// ===== sv/reee_if.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
`default_nettype none
interface reee_req_if;
   logic valid;
   logic ready;
   logic [2:0] action;
   logic signed [8:0] peer_id;
   logic signed [31:0] peer_term;
   modport source (output valid, action, peer_id, peer_term, input ready);
   modport sink (input valid, action, peer_id, peer_term, output ready);
endinterface

interface reee_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] kind;
   logic [30:0] term;
   logic [1:0] role;
   logic signed [8:0] leader;
   logic signed [8:0] vote;
   logic last;
   modport source (output valid, kind, term, role, leader, vote, last, input ready);
   modport sink (input valid, kind, term, role, leader, vote, last, output ready);
endinterface

interface reee_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/reee_mod_unit.sv =====
// Restoring serial remainder unit, one quotient bit per cycle.
`default_nettype none
module reee_mod_unit
   import reee_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mod_req_type mod_req,
   output mod_rsp_type      mod_rsp
);
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff, quo_ff[15]};
      if (mod_req.start) begin
         rem_in = '0;
         quo_in = mod_req.dividend;
         div_in = mod_req.divisor;
         cnt_in = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 16'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[15:0];
         end
         quo_in = {quo_ff[14:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign mod_rsp.done = busy_ff && (cnt_ff == 5'd1);
   assign mod_rsp.remainder = rem_in;
endmodule
`default_nettype wire

// ===== sv/raft_election_engine.sv =====
// Top level of the election engine: state, sequencer and response buffer.
//
// Channel   Dir   Handshake       Payload
// req_      in    valid/ready     action, peer_id, peer_term
// rsp_      out   valid/ready     kind, term, role, leader, vote, last
// csr_      in    valid/ready     index, data
//
// The first response of a request is offered after the request is taken and
// passes the execute and finish states; when a new election deadline is drawn
// the jitter remainder first runs through the serial remainder unit in its own
// state, one bit per cycle. Up to two responses drain from a small buffer; the
// block takes the next request once all of them are gone. Reset is
// synchronous and returns every control register to its power-up value.
// Register writes are always accepted.
`default_nettype none
module raft_election_engine
   import reee_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDefault,
   parameter int TIME_BITS = TimeBitsDefault
)(
   input wire logic clock,
   input wire logic reset,
   reee_req_if.sink req_ch,
   reee_rsp_if.source rsp_ch,
   reee_csr_if.sink csr_ch
);
   localparam int CntBits = $clog2(MAX_NODES + 1);
   localparam logic [CntBits-1:0] CntMax = CntBits'(MAX_NODES);

   logic [7:0]  own_id_ff;
   logic [8:0]  cluster_ff;
   logic [15:0] ka_ff, hb_ff;

   state_type state_ff, state_in;
   role_type  role_ff, role_in;
   logic [30:0] term_ff, term_in;
   logic signed [8:0] voted_ff, voted_in, leader_ff, leader_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic open_ff, open_in;
   logic [TIME_BITS-1:0] now_ff, now_in, heard_ff, heard_in, dead_ff, dead_in;
   logic [TIME_BITS-1:0] beat_ff, beat_in, ask_ff, ask_in;
   logic [15:0] lfsr_ff, lfsr_in;

   action_type act_ff, act_in;
   logic signed [8:0]  pid_ff, pid_in;
   logic [31:0] ptm_ff, ptm_in;
   logic deadline_ff, deadline_in;   // deadline draw pending after exec
   logic [2:0] post_ff, post_in;     // kinds queued after the draw, as flags

   logic [2:0] k0_ff, k0_in, k1_ff, k1_in;
   logic [1:0] n_ff, n_in, sent_ff, sent_in;
   logic [30:0] oterm_ff, oterm_in, oterm0_ff, oterm0_in;
   role_type orole_ff, orole_in;
   logic signed [8:0] olead_ff, olead_in, ovote_ff, ovote_in, ovote0_ff, ovote0_in;

   mod_req_type mod_req;
   mod_rsp_type mod_rsp;
   logic [15:0] ka_base, hb_base;
   logic [8:0]  size;
   logic [TIME_BITS-1:0] tnext;
   logic id_ok, term_ok;
   logic signed [8:0] cand;

   reee_mod_unit u_mod (.clock(clock), .reset(reset), .mod_req(mod_req), .mod_rsp(mod_rsp));

   assign ka_base = (ka_ff == '0) ? 16'd5 : ka_ff;
   assign hb_base = (hb_ff == '0) ? 16'd1 : hb_ff;
   assign size = ({23'd0, cluster_ff} > MAX_NODES) ? 9'(MAX_NODES) : cluster_ff;
   assign id_ok = ~pid_ff[8];
   assign term_ok = ~ptm_ff[31];
   assign cand = id_ok ? pid_ff : 9'sd0;
   assign tnext = now_ff + TIME_BITS'(1);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = (state_ff == ST_OUT);
   assign rsp_ch.kind = (sent_ff == 2'd0) ? k0_ff : k1_ff;
   // With two responses the first one shows the state before the new election.
   assign rsp_ch.term = (sent_ff == 2'd0 && n_ff == 2'd2) ? oterm0_ff : oterm_ff;
   assign rsp_ch.role = orole_ff;
   assign rsp_ch.leader = olead_ff;
   assign rsp_ch.vote = (sent_ff == 2'd0 && n_ff == 2'd2) ? ovote0_ff : ovote_ff;
   assign rsp_ch.last = (2'(sent_ff + 2'd1) == n_ff);

   always_comb begin
      state_in = state_ff; role_in = role_ff; term_in = term_ff;
      voted_in = voted_ff; leader_in = leader_ff; count_in = count_ff;
      open_in = open_ff; now_in = now_ff; heard_in = heard_ff; dead_in = dead_ff;
      beat_in = beat_ff; ask_in = ask_ff; lfsr_in = lfsr_ff;
      act_in = act_ff; pid_in = pid_ff; ptm_in = ptm_ff;
      deadline_in = deadline_ff; post_in = post_ff;
      k0_in = k0_ff; k1_in = k1_ff; n_in = n_ff; sent_in = sent_ff;
      oterm_in = oterm_ff; orole_in = orole_ff; olead_in = olead_ff; ovote_in = ovote_ff;
      oterm0_in = oterm0_ff; ovote0_in = ovote0_ff;
      mod_req.start = 1'b0;
      mod_req.dividend = lfsr_step(lfsr_ff);
      mod_req.divisor = ka_base;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               act_in = action_type'(req_ch.action);
               pid_in = req_ch.peer_id;
               ptm_in = req_ch.peer_term;
               n_in = 2'd0; sent_in = 2'd0;
               deadline_in = 1'b0; post_in = 3'd0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // post_in[0]: emit granted; [1]: vote bcast with ask update;
            // [2]: vote bcast clearing the ask time.
            state_in = ST_FINISH;
            oterm0_in = term_ff; ovote0_in = voted_ff;
            unique case (act_ff)
               ACT_VOTE_REQ: begin
                  if (term_ok && ptm_ff[30:0] < term_ff) begin
                     k0_in = KIND_DENIED; n_in = 2'd1;
                  end else begin
                     role_type r;
                     logic signed [8:0] v;
                     r = role_ff; v = voted_ff;
                     if (term_ok && ptm_ff[30:0] > term_ff) begin
                        term_in = ptm_ff[30:0]; v = -9'sd1; r = ROLE_FOL;
                        open_in = 1'b0; count_in = '0;
                     end
                     voted_in = v; role_in = r;
                     if (r != ROLE_LEAD && (v == -9'sd1 || v == cand)) begin
                        voted_in = cand;
                        post_in[0] = 1'b1;
                     end
                     // Stepping down draws once and granting draws again.
                     if (term_ok && ptm_ff[30:0] > term_ff) begin
                        lfsr_in = lfsr_step(lfsr_ff);
                     end
                     deadline_in = 1'b1;
                     if (!(term_ok && ptm_ff[30:0] > term_ff) && !post_in[0]) begin
                        deadline_in = 1'b0;
                     end
                  end
               end
               ACT_HEARTBEAT: begin
                  heard_in = now_ff;
                  if (term_ok && ptm_ff[30:0] > term_ff) begin
                     term_in = ptm_ff[30:0]; voted_in = -9'sd1;
                  end
                  if (id_ok) begin
                     role_in = ROLE_FOL; leader_in = pid_ff;
                     open_in = 1'b0; count_in = '0; deadline_in = 1'b1;
                  end
                  k0_in = KIND_HB_ACK; n_in = 2'd1;
               end
               ACT_GRANT: begin
                  if (open_ff && !(term_ok && ptm_ff[30:0] > term_ff)) begin
                     logic [CntBits-1:0] c;
                     c = (count_ff < CntMax) ? CntBits'(count_ff + 1'b1) : count_ff;
                     count_in = c;
                     if (32'(c) > 32'(size >> 1)) begin
                        role_in = ROLE_LEAD; leader_in = {1'b0, own_id_ff};
                        open_in = 1'b0; count_in = '0; beat_in = '0;
                        k0_in = KIND_ELECTED; n_in = 2'd1;
                     end
                  end
               end
               ACT_TIMEOUT: begin
                  if (TIME_BITS'(now_ff - heard_ff) > TIME_BITS'(ka_ff)) begin
                     if (term_ff < TermMax) term_in = term_ff + 31'd1;
                     voted_in = {1'b0, own_id_ff}; role_in = ROLE_CAND;
                     open_in = 1'b1; count_in = CntBits'(1);
                     deadline_in = 1'b1; post_in[2] = 1'b1;
                  end
               end
               ACT_TICK: begin
                  now_in = tnext;
                  priority case (role_ff)
                     ROLE_LEAD: begin
                        if (tnext >= beat_ff) begin
                           k0_in = KIND_HB_BCAST; n_in = 2'd1;
                           beat_in = tnext + TIME_BITS'(hb_base);
                        end
                     end
                     ROLE_CAND: begin
                        logic [1:0] n;
                        n = 2'd0;
                        if (tnext >= ask_ff) begin
                           k0_in = KIND_VOTE_BCAST; n = 2'd1;
                           ask_in = tnext + TIME_BITS'(1);
                        end
                        n_in = n;
                        if (tnext > dead_ff) begin
                           if (term_ff < TermMax) term_in = term_ff + 31'd1;
                           voted_in = {1'b0, own_id_ff}; open_in = 1'b1;
                           count_in = CntBits'(1); deadline_in = 1'b1; post_in[1] = 1'b1;
                        end
                     end
                     default: begin
                        if (tnext > TIME_BITS'(heard_ff + TIME_BITS'(ka_base))) begin
                           if (term_ff < TermMax) term_in = term_ff + 31'd1;
                           voted_in = {1'b0, own_id_ff}; role_in = ROLE_CAND;
                           open_in = 1'b1; count_in = CntBits'(1);
                           deadline_in = 1'b1; post_in[1] = 1'b1;
                        end
                     end
                  endcase
               end
               ACT_TRIGGER: begin
                  heard_in = '0; dead_in = now_ff;
                  k0_in = KIND_OK; n_in = 2'd1;
               end
               ACT_STEP_DOWN: begin
                  role_in = ROLE_FOL; open_in = 1'b0; count_in = '0;
                  deadline_in = 1'b1; post_in = 3'd0;
                  k0_in = KIND_OK; n_in = 2'd0;
                  post_in[0] = 1'b0;
               end
               default: ;
            endcase
            if (deadline_in) begin
               state_in = ST_MOD;
               mod_req.start = 1'b1;
               mod_req.dividend = lfsr_step(lfsr_in);
            end
         end
         ST_MOD: begin
            if (mod_rsp.done) begin
               lfsr_in = lfsr_step(lfsr_ff);
               dead_in = now_ff + TIME_BITS'({1'b0, ka_base} + {1'b0, mod_rsp.remainder});
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (deadline_ff && act_ff == ACT_STEP_DOWN) begin
               k0_in = KIND_OK; n_in = 2'd1;
            end
            if (post_ff[0]) begin
               k0_in = KIND_GRANTED; n_in = 2'd1;
            end
            if (post_ff[2]) begin
               ask_in = '0; k0_in = KIND_VOTE_BCAST; n_in = 2'd1;
            end
            if (post_ff[1]) begin
               ask_in = now_ff + TIME_BITS'(1);
               if (n_ff == 2'd1) begin
                  k1_in = KIND_VOTE_BCAST; n_in = 2'd2;
               end else begin
                  k0_in = KIND_VOTE_BCAST; n_in = 2'd1;
               end
            end
            oterm_in = term_ff; orole_in = role_ff;
            olead_in = leader_ff; ovote_in = voted_ff;
            state_in = (n_in == 2'd0) ? ST_IDLE : ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               sent_in = sent_ff + 2'd1;
               if (2'(sent_ff + 2'd1) == n_ff) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_ch.valid && csr_ch.index == CSR_SEED) begin
         lfsr_in = (csr_ch.data == '0) ? SeedReset : csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; pid_ff <= pid_in; ptm_ff <= ptm_in;
      k0_ff <= k0_in; k1_ff <= k1_in;
      oterm_ff <= oterm_in; orole_ff <= orole_in; olead_ff <= olead_in; ovote_ff <= ovote_in;
      oterm0_ff <= oterm0_in; ovote0_ff <= ovote0_in;
      if (reset) begin
         state_ff <= ST_IDLE; role_ff <= ROLE_FOL; term_ff <= '0;
         voted_ff <= -9'sd1; leader_ff <= -9'sd1; count_ff <= '0; open_ff <= 1'b0;
         now_ff <= '0; heard_ff <= '0; dead_ff <= TIME_BITS'(5);
         beat_ff <= TIME_BITS'(1); ask_ff <= '0; lfsr_ff <= SeedReset;
         deadline_ff <= 1'b0; post_ff <= '0; n_ff <= '0; sent_ff <= '0;
         own_id_ff <= '0; cluster_ff <= 9'd1; ka_ff <= '0; hb_ff <= '0;
      end else begin
         state_ff <= state_in; role_ff <= role_in; term_ff <= term_in;
         voted_ff <= voted_in; leader_ff <= leader_in; count_ff <= count_in;
         open_ff <= open_in; now_ff <= now_in; heard_ff <= heard_in; dead_ff <= dead_in;
         beat_ff <= beat_in; ask_ff <= ask_in; lfsr_ff <= lfsr_in;
         deadline_ff <= deadline_in; post_ff <= post_in; n_ff <= n_in; sent_ff <= sent_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_OWN_ID:    own_id_ff <= csr_ch.data[7:0];
               CSR_CLUSTER:   cluster_ff <= csr_ch.data[8:0];
               CSR_KEEPALIVE: ka_ff <= csr_ch.data;
               CSR_HB_PERIOD: hb_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ===== sv/reee_checker.sv =====
// Port-level checks of the election engine, bound to the top level.
`default_nettype none
module reee_checker
   import reee_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_last,
   input wire logic [1:0] rsp_role
);
   // A response is never offered while a request can be taken.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("response and request ready together");
   // After the last response the block is ready again.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not ready after last response");
   // A taken request makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready right after request");
   // The reported role is always a defined one.
   a_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_role != ROLE_RSV) else $error("undefined role");
endmodule

bind raft_election_engine reee_checker u_reee_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_last(rsp_ch.last), .rsp_role(rsp_ch.role)
);
`default_nettype wire

// ===== tb/sv/raft_election_engine_checker.sv =====
// Checker for the election engine: predicts every response and compares it.
`timescale 1ns / 100ps
`default_nettype none
module raft_election_engine_checker
   import reee_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   reee_req_if req_ch,
   reee_rsp_if rsp_ch,
   reee_csr_if csr_ch,
   output int errors,
   output int pending,
   output logic [30:0] cur_term
);
   typedef struct packed {
      kind_type kind;
      logic [30:0] term;
      role_type role;
      logic signed [8:0] leader;
      logic signed [8:0] vote;
      logic last;
   } notice_t;

   notice_t due_q[$];
   notice_t step_out[$];

   logic [7:0] own_id;
   logic [8:0] cluster;
   logic [15:0] keepalive;
   logic [15:0] hb_period;

   role_type role;
   logic [30:0] term;
   logic signed [8:0] voted;
   logic signed [8:0] leader;
   int votes;
   logic open;
   logic [31:0] now_s, heard_s, deadline_s, beat_due_s, ask_due_s;
   logic [15:0] lfsr;

   assign pending = due_q.size();
   assign cur_term = term;

   function logic [31:0] keepalive_base();
      return (keepalive != 0) ? {16'd0, keepalive} : 32'd5;
   endfunction

   function logic [31:0] beat_base();
      return (hb_period != 0) ? {16'd0, hb_period} : 32'd1;
   endfunction

   function void draw_deadline();
      logic [31:0] base;
      base = keepalive_base();
      lfsr = lfsr_step(lfsr);
      deadline_s = now_s + base + ({16'd0, lfsr} % base);
   endfunction

   function void announce(kind_type k);
      notice_t n;
      n = '{kind: k, term: term, role: role, leader: leader, vote: voted, last: 1'b0};
      if (step_out.size() < 2) begin
         step_out.push_back(n);
      end
   endfunction

   function void become_follower(logic signed [8:0] known);
      role = ROLE_FOL;
      if (known >= 0) begin
         leader = known;
      end
      open = 1'b0;
      votes = 0;
      draw_deadline();
   endfunction

   function void start_election();
      if (term < TermMax) begin
         term = term + 31'd1;
      end
      voted = $signed({1'b0, own_id});
      role = ROLE_CAND;
      open = 1'b1;
      votes = 1;
      draw_deadline();
   endfunction

   function void call_for_votes();
      announce(KIND_VOTE_BCAST);
      ask_due_s = now_s + 32'd1;
   endfunction

   function void predict_election(logic [2:0] act, logic [8:0] id, logic [31:0] pterm);
      logic id_ok, term_ok;
      logic signed [8:0] cand;
      int size;
      id_ok = !id[8];
      term_ok = !pterm[31];
      size = (cluster > MaxNodesDefault) ? MaxNodesDefault : cluster;
      step_out.delete();
      case (action_type'(act))
         ACT_VOTE_REQ: begin
            cand = id_ok ? $signed(id) : 9'sd0;
            if (term_ok && pterm < {1'b0, term}) begin
               announce(KIND_DENIED);
            end else begin
               if (term_ok && pterm > {1'b0, term}) begin
                  term = pterm[30:0];
                  voted = -9'sd1;
                  become_follower(-9'sd1);
               end
               if (role != ROLE_LEAD && (voted == -9'sd1 || voted == cand)) begin
                  voted = cand;
                  draw_deadline();
                  announce(KIND_GRANTED);
               end
            end
         end
         ACT_HEARTBEAT: begin
            heard_s = now_s;
            if (term_ok && pterm > {1'b0, term}) begin
               term = pterm[30:0];
               voted = -9'sd1;
            end
            if (id_ok) begin
               become_follower($signed(id));
            end
            announce(KIND_HB_ACK);
         end
         ACT_GRANT: begin
            if (open && !(term_ok && pterm > {1'b0, term})) begin
               if (votes < MaxNodesDefault) begin
                  votes++;
               end
               if (votes > size / 2) begin
                  role = ROLE_LEAD;
                  leader = $signed({1'b0, own_id});
                  open = 1'b0;
                  votes = 0;
                  beat_due_s = 32'd0;
                  announce(KIND_ELECTED);
               end
            end
         end
         ACT_TIMEOUT: begin
            if (now_s - heard_s > {16'd0, keepalive}) begin
               start_election();
               ask_due_s = 32'd0;
               announce(KIND_VOTE_BCAST);
            end
         end
         ACT_TICK: begin
            now_s = now_s + 32'd1;
            if (role == ROLE_LEAD) begin
               if (now_s >= beat_due_s) begin
                  announce(KIND_HB_BCAST);
                  beat_due_s = now_s + beat_base();
               end
            end else if (role == ROLE_CAND) begin
               if (now_s >= ask_due_s) begin
                  call_for_votes();
               end
               if (now_s > deadline_s) begin
                  start_election();
                  call_for_votes();
               end
            end else if (now_s > heard_s + keepalive_base()) begin
               start_election();
               call_for_votes();
            end
         end
         ACT_TRIGGER: begin
            heard_s = 32'd0;
            deadline_s = now_s;
            announce(KIND_OK);
         end
         ACT_STEP_DOWN: begin
            become_follower(-9'sd1);
            announce(KIND_OK);
         end
         default: begin
         end
      endcase
      foreach (step_out[i]) begin
         step_out[i].last = (i == step_out.size() - 1);
         due_q.push_back(step_out[i]);
      end
   endfunction

   always @(posedge clock) begin
      notice_t want;
      if (reset) begin
         own_id = 8'd0;
         cluster = 9'd1;
         keepalive = 16'd0;
         hb_period = 16'd0;
         role = ROLE_FOL;
         term = '0;
         voted = -9'sd1;
         leader = -9'sd1;
         votes = 0;
         open = 1'b0;
         now_s = 32'd0;
         heard_s = 32'd0;
         deadline_s = 32'd5;
         beat_due_s = 32'd1;
         ask_due_s = 32'd0;
         lfsr = SeedReset;
         due_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response kind=%0d term=%0d", $time,
                        rsp_ch.kind, rsp_ch.term);
            end else begin
               want = due_q.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.term !== want.term
                     || rsp_ch.role !== want.role || rsp_ch.leader !== want.leader
                     || rsp_ch.vote !== want.vote || rsp_ch.last !== want.last) begin
                  errors++;
                  $display("%0t: mismatch expected kind=%0d term=%0d role=%0d leader=%0d vote=%0d last=%0d",
                           $time, want.kind, want.term, want.role, want.leader,
                           want.vote, want.last);
                  $display("%0t:          actual kind=%0d term=%0d role=%0d leader=%0d vote=%0d last=%0d",
                           $time, rsp_ch.kind, rsp_ch.term, rsp_ch.role, rsp_ch.leader,
                           rsp_ch.vote, rsp_ch.last);
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_OWN_ID: own_id = csr_ch.data[7:0];
               CSR_CLUSTER: cluster = csr_ch.data[8:0];
               CSR_KEEPALIVE: keepalive = csr_ch.data;
               CSR_HB_PERIOD: hb_period = csr_ch.data;
               CSR_SEED: lfsr = (csr_ch.data != 0) ? csr_ch.data : SeedReset;
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_election(req_ch.action, req_ch.peer_id, req_ch.peer_term);
         end
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/raft_election_engine_tb.sv =====
// Top of the election engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module raft_election_engine_tb;
   import reee_pkg::*;

   typedef struct packed {
      action_type act;
      logic [8:0] id;
      logic [31:0] pterm;
   } message_type;

   logic clock = 1'b0;
   logic reset;
   int errors;
   int pending;
   logic [30:0] cur_term;
   int idle_cycles = 0;
   int served = 0;
   logic send_burst = 1'b0;
   logic recv_burst = 1'b0;

   reee_req_if req_bus();
   reee_rsp_if rsp_bus();
   reee_csr_if csr_bus();

   raft_election_engine dut (
      .clock(clock), .reset(reset), .req_ch(req_bus), .rsp_ch(rsp_bus), .csr_ch(csr_bus)
   );

   raft_election_engine_checker checker_i (
      .clock(clock), .reset(reset), .req_ch(req_bus), .rsp_ch(rsp_bus), .csr_ch(csr_bus),
      .errors(errors), .pending(pending), .cur_term(cur_term)
   );

   always #6 clock = ~clock;

   // Any accepted transfer counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 5000) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(message_type m, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= m.act;
      req_bus.peer_id <= m.id;
      req_bus.peer_term <= m.pterm;
      @(posedge clock iff req_bus.ready);
   endtask

   task automatic write_reg(csr_type idx, logic [15:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock iff csr_bus.ready);
   endtask

   // Registers change only once every response of the previous phase is back.
   task automatic program_regs(logic [7:0] own, logic [8:0] size, logic [15:0] keep,
                               logic [15:0] beat, logic [15:0] seed);
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (40) @(posedge clock);
      write_reg(CSR_OWN_ID, {8'd0, own});
      write_reg(CSR_CLUSTER, {7'd0, size});
      write_reg(CSR_KEEPALIVE, keep);
      write_reg(CSR_HB_PERIOD, beat);
      write_reg(CSR_SEED, seed);
      // An index past the last register must be ignored.
      csr_bus.valid <= 1'b1;
      csr_bus.index <= 3'd7;
      csr_bus.data <= 16'hFFFF;
      @(posedge clock iff csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic message_type random_message(bit wide);
      message_type m;
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) m.act = ACT_TICK;
      else if (r < 50) m.act = ACT_VOTE_REQ;
      else if (r < 60) m.act = ACT_HEARTBEAT;
      else if (r < 75) m.act = ACT_GRANT;
      else if (r < 83) m.act = ACT_TIMEOUT;
      else if (r < 88) m.act = ACT_TRIGGER;
      else if (r < 94) m.act = ACT_STEP_DOWN;
      else if (r < 96) m.act = ACT_NONE;
      else m.act = ACT_TICK;
      r = $urandom_range(0, 99);
      if (r < 60) m.id = 9'($urandom_range(0, 7));
      else if (r < 80) m.id = 9'($urandom_range(0, 255));
      else m.id = 9'($urandom_range(256, 511));
      r = $urandom_range(0, 99);
      if (wide && r < 30) m.pterm = $urandom;
      else if (r < 70) m.pterm = {1'b0, cur_term} + $urandom_range(0, 2)
                                  - ((cur_term != 0) ? 1 : 0);
      else if (r < 85) m.pterm = 32'hFFFF_FFFF;
      else if (r < 95) m.pterm = $urandom | 32'h8000_0000;
      else m.pterm = {1'b0, cur_term} + $urandom_range(0, 20);
      return m;
   endfunction

   task automatic random_phase(int count, bit wide);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 49) == 0) begin
            send_burst = ~send_burst;
         end
         send_request(random_message(wide), send_burst ? 0 : $urandom_range(0, 18));
      end
   endtask

   task automatic directed_list(message_type list[$]);
      foreach (list[i]) begin
         send_request(list[i], $urandom_range(0, 3));
      end
   endtask

   initial begin
      message_type opening[$];
      message_type closing[$];
      opening = '{
         '{ACT_VOTE_REQ, 9'h1FF, 32'hFFFF_FFFF}, '{ACT_VOTE_REQ, 9'd5, 32'd0},
         '{ACT_VOTE_REQ, 9'd5, 32'd3}, '{ACT_VOTE_REQ, 9'd6, 32'd1},
         '{ACT_HEARTBEAT, 9'd2, 32'd3}, '{ACT_HEARTBEAT, 9'h1FF, 32'hFFFF_FFFF},
         '{ACT_TIMEOUT, 9'd0, 32'd0}, '{ACT_TICK, 9'd0, 32'd0}, '{ACT_TICK, 9'd0, 32'd0},
         '{ACT_TICK, 9'd0, 32'd0}, '{ACT_TICK, 9'd0, 32'd0}, '{ACT_TICK, 9'd0, 32'd0},
         '{ACT_TICK, 9'd0, 32'd0}, '{ACT_GRANT, 9'd1, 32'd99}, '{ACT_GRANT, 9'd1, 32'd4},
         '{ACT_GRANT, 9'd2, 32'hFFFF_FFFF}, '{ACT_GRANT, 9'd4, 32'd4},
         '{ACT_GRANT, 9'd4, 32'd4}, '{ACT_TICK, 9'd0, 32'd0}, '{ACT_VOTE_REQ, 9'd1, 32'd4},
         '{ACT_TRIGGER, 9'd0, 32'd0}, '{ACT_STEP_DOWN, 9'd0, 32'd0},
         '{ACT_NONE, 9'd255, 32'h7FFF_FFFF}, '{ACT_TIMEOUT, 9'd0, 32'd0}
      };
      // Saturated term: elections can no longer raise it.
      closing = '{
         '{ACT_VOTE_REQ, 9'd255, 32'h7FFF_FFFF}, '{ACT_TIMEOUT, 9'd0, 32'd0},
         '{ACT_TRIGGER, 9'd0, 32'd0}, '{ACT_TICK, 9'd0, 32'd0}, '{ACT_TICK, 9'd0, 32'd0},
         '{ACT_GRANT, 9'd3, 32'h7FFF_FFFF}, '{ACT_GRANT, 9'd3, 32'h7FFF_FFFF},
         '{ACT_TICK, 9'd0, 32'd0}
      };
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_NONE;
      req_bus.peer_id <= '0;
      req_bus.peer_term <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_OWN_ID;
      csr_bus.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_regs(8'd3, 9'd5, 16'd0, 16'd0, 16'd0);
      directed_list(opening);
      program_regs(8'd0, 9'd1, 16'd2, 16'd1, 16'd1);
      random_phase(200, 1'b0);
      program_regs(8'd255, 9'd256, 16'd0, 16'd3, 16'hFFFF);
      random_phase(200, 1'b0);
      program_regs(8'd7, 9'd3, 16'hFFFF, 16'hFFFF, 16'd12345);
      random_phase(150, 1'b0);
      program_regs(8'd42, 9'd511, 16'd1, 16'd0, 16'($urandom_range(1, 65535)));
      random_phase(200, 1'b0);
      program_regs(8'd9, 9'd300, 16'd4, 16'd2, 16'd777);
      random_phase(150, 1'b0);
      program_regs(8'd1, 9'd2, 16'd0, 16'd0, 16'd44257);
      random_phase(150, 1'b1);
      directed_list(closing);
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Response side; one long hold-off lets the block back up into its input.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            recv_burst = ~recv_burst;
         end
         stall = recv_burst ? 0 : $urandom_range(0, 18);
         if (served == 300) begin
            stall = 600;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock iff rsp_bus.valid);
         served++;
      end
   end
endmodule
`default_nettype wire
